@@ rtl/tmrcq_pkg.sv @@
// Shared types, constants and helpers for the tilemap rectangle collision query.
package tmrcq_pkg;

	// Default store dimensions.
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 128;

	// Width of the pixel-edge dividend magnitudes and of the quotients.
	localparam int QW = 17;
	// Width of the tile size (divisor) and of the divider remainder.
	localparam int TSW = 8;
	// Width of the divider step counter.
	localparam int DCW = $clog2(QW + 1);
	// Width used to range-check tile coordinates against the store size.
	localparam int LIMW = 11;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAP_ENABLED = 2'd0;
	localparam logic [1:0] REG_TILE_SIZE   = 2'd1;
	localparam logic [1:0] REG_ROW_COUNT   = 2'd2;
	localparam logic [1:0] REG_COL_COUNT   = 2'd3;

	// Configuration reset values.
	localparam logic           MAP_ENABLED_RST = 1'b0;
	localparam logic [TSW-1:0] TILE_SIZE_RST   = 8'd32;
	localparam logic [6:0]     ROW_COUNT_RST   = 7'd20;
	localparam logic [7:0]     COL_COUNT_RST   = 8'd80;

	// Function codes of an input word.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EVAL,
		ST_WALK,
		ST_DRAIN
	} state_t;

	// Magnitude of a two's complement value; the sign is tracked separately.
	function automatic logic [QW-1:0] mag(input logic [QW-1:0] v);
		mag = v[QW-1] ? (~v + QW'(1)) : v;
	endfunction

endpackage

@@ rtl/tilemap_rect_collision_query.sv @@
// Top level of the tilemap rectangle collision query: config, map memory and walk control.
//
// Usage
//   Input words are accepted at a rising edge with start high and busy low.
//   func = 0 writes one tile of the solid map (solid when tile_value > 0);
//   the write is stored at that edge, busy stays low and no result follows.
//   func = 1 queries the rectangle query_x/y/w/h. Its edges are divided by
//   tile_size in four parallel bit-serial dividers, the tile range is
//   clamped to the map, then the map memory is read one tile per cycle,
//   stopping at the first solid tile.
//   The answer appears on hit with done high for exactly one cycle; the
//   receiver cannot stall it. No tile is read when the map is disabled or
//   the range is empty; a walk ends early if a solid tile is found. busy
//   is high from the accepting edge until done rises; it falls in the
//   cycle that carries done.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
//   write it only while idle, as the block does not enforce this. Reset clears
//   the configuration to its defaults and the control state; the map content
//   is undefined until written, so write every tile that a query may cover.
module tilemap_rect_collision_query #(
	parameter int MAX_ROWS = tmrcq_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = tmrcq_pkg::DEF_MAX_COLS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [5:0]                  tile_row,
	input  logic [6:0]                  tile_col,
	input  logic signed [15:0]          tile_value,
	input  logic signed [15:0]          query_x,
	input  logic signed [15:0]          query_y,
	input  logic [14:0]                 query_w,
	input  logic [14:0]                 query_h,
	output logic                        done,
	output logic                        hit,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [tmrcq_pkg::TSW-1:0]   cfg_wdata
);

	localparam int QW    = tmrcq_pkg::QW;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers
	logic                      map_en_q;
	logic [tmrcq_pkg::TSW-1:0] tile_size_q;
	logic [6:0]                row_count_q;
	logic [7:0]                col_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_en_q    <= tmrcq_pkg::MAP_ENABLED_RST;
			tile_size_q <= tmrcq_pkg::TILE_SIZE_RST;
			row_count_q <= tmrcq_pkg::ROW_COUNT_RST;
			col_count_q <= tmrcq_pkg::COL_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tmrcq_pkg::REG_MAP_ENABLED: map_en_q    <= cfg_wdata[0];
				tmrcq_pkg::REG_TILE_SIZE:   tile_size_q <= cfg_wdata;
				tmrcq_pkg::REG_ROW_COUNT:   row_count_q <= cfg_wdata[6:0];
				tmrcq_pkg::REG_COL_COUNT:   col_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Control state
	tmrcq_pkg::state_t state_q, state_nxt;

	logic accept;
	logic q_load;
	logic div_step;
	logic issue;
	logic fin;
	logic fin_hit;
	logic found;
	logic last;
	logic go_walk;

	logic [tmrcq_pkg::DCW-1:0] div_cnt_q;

	assign busy   = (state_q != tmrcq_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign q_load = accept && (func == tmrcq_pkg::FUNC_QUERY);

	// Tile write path: store at the accepting edge, drop writes outside the map.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_bit;

	always_comb begin
		wr_en   = accept && (func == tmrcq_pkg::FUNC_WRITE)
			&& (tmrcq_pkg::LIMW'(tile_row) < tmrcq_pkg::LIMW'(MAX_ROWS))
			&& (tmrcq_pkg::LIMW'(tile_col) < tmrcq_pkg::LIMW'(MAX_COLS));
		wr_addr = AW'(tile_row) * AW'(MAX_COLS) + AW'(tile_col);
		wr_bit  = !tile_value[15] && (tile_value != 16'sd0);
	end

	// Edge dividends: left/top edge and right/bottom edge, sign kept apart.
	logic [QW-1:0] nx, ny, nr, nb;
	logic          negx_q, negy_q, negr_q, negb_q;

	always_comb begin
		nx = {query_x[15], query_x};
		ny = {query_y[15], query_y};
		nr = nx + {2'b00, query_w};
		nb = ny + {2'b00, query_h};
	end

	always_ff @(posedge clk) begin
		if (q_load) begin
			negx_q <= nx[QW-1];
			negy_q <= ny[QW-1];
			negr_q <= nr[QW-1];
			negb_q <= nb[QW-1];
		end
	end

	// Divisor: a zero tile size acts as one.
	logic [tmrcq_pkg::TSW-1:0] ts;
	assign ts = (tile_size_q == '0) ? tmrcq_pkg::TSW'(1) : tile_size_q;

	logic [QW-1:0] qx, qy, qr, qb;

	tmrcq_div u_div_x (
		.clk (clk), .load (q_load), .step (div_step),
		.dvd (tmrcq_pkg::mag(nx)), .dvs (ts), .quo (qx)
	);
	tmrcq_div u_div_y (
		.clk (clk), .load (q_load), .step (div_step),
		.dvd (tmrcq_pkg::mag(ny)), .dvs (ts), .quo (qy)
	);
	tmrcq_div u_div_r (
		.clk (clk), .load (q_load), .step (div_step),
		.dvd (tmrcq_pkg::mag(nr)), .dvs (ts), .quo (qr)
	);
	tmrcq_div u_div_b (
		.clk (clk), .load (q_load), .step (div_step),
		.dvd (tmrcq_pkg::mag(nb)), .dvs (ts), .quo (qb)
	);

	// Clamp the tile range to the map. Quotients truncate toward zero, so a
	// negative far edge still lands on tile 0 unless it is a whole tile out.
	logic [QW-1:0] col_lim, row_lim, col_max, row_max;
	logic [QW-1:0] lft, rgt, top, bot, rgt_cl, bot_cl;
	logic          empty_c, empty_r;

	always_comb begin
		col_lim = (QW'(col_count_q) > QW'(MAX_COLS)) ? QW'(MAX_COLS) : QW'(col_count_q);
		row_lim = (QW'(row_count_q) > QW'(MAX_ROWS)) ? QW'(MAX_ROWS) : QW'(row_count_q);
		col_max = col_lim - QW'(1);
		row_max = row_lim - QW'(1);
		lft     = negx_q ? '0 : qx;
		top     = negy_q ? '0 : qy;
		rgt     = negr_q ? '0 : qr;
		bot     = negb_q ? '0 : qb;
		rgt_cl  = (rgt > col_max) ? col_max : rgt;
		bot_cl  = (bot > row_max) ? row_max : bot;
		empty_c = (col_lim == '0) || (negr_q && (qr != '0)) || (lft > rgt_cl);
		empty_r = (row_lim == '0) || (negb_q && (qb != '0)) || (top > bot_cl);
		go_walk = map_en_q && !empty_c && !empty_r;
	end

	// Walk bounds and position
	logic [CW-1:0] left_q, right_q, c_q;
	logic [RW-1:0] top_q, bot_q, r_q;

	// Map memory: one read port for the walk, one write port for tile writes.
	logic          mem [DEPTH];
	logic [AW-1:0] rd_addr;
	logic          rd_data_s1;
	logic          rd_vld_s1;

	assign rd_addr = AW'(r_q) * AW'(MAX_COLS) + AW'(c_q);
	assign found   = rd_vld_s1 && rd_data_s1;
	assign last    = (r_q == bot_q) && (c_q == right_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tmrcq_pkg::ST_IDLE: begin
				if (q_load) state_nxt = tmrcq_pkg::ST_DIV;
			end
			tmrcq_pkg::ST_DIV: begin
				if (div_cnt_q == tmrcq_pkg::DCW'(QW - 1)) state_nxt = tmrcq_pkg::ST_EVAL;
			end
			tmrcq_pkg::ST_EVAL: begin
				state_nxt = go_walk ? tmrcq_pkg::ST_WALK : tmrcq_pkg::ST_IDLE;
			end
			tmrcq_pkg::ST_WALK: begin
				if (found) state_nxt = tmrcq_pkg::ST_IDLE;
				else if (last) state_nxt = tmrcq_pkg::ST_DRAIN;
			end
			tmrcq_pkg::ST_DRAIN: begin
				state_nxt = tmrcq_pkg::ST_IDLE;
			end
			default: state_nxt = tmrcq_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		div_step = 1'b0;
		issue    = 1'b0;
		fin      = 1'b0;
		fin_hit  = 1'b0;
		case (state_q)
			tmrcq_pkg::ST_DIV: begin
				div_step = 1'b1;
			end
			tmrcq_pkg::ST_EVAL: begin
				fin = !go_walk;
			end
			tmrcq_pkg::ST_WALK: begin
				// A solid tile ends the walk; drop the read issued behind it.
				issue   = !found;
				fin     = found;
				fin_hit = 1'b1;
			end
			tmrcq_pkg::ST_DRAIN: begin
				fin     = 1'b1;
				fin_hit = rd_data_s1;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tmrcq_pkg::ST_IDLE;
			div_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= issue;
			done      <= fin;
			if (q_load) div_cnt_q <= '0;
			else if (div_step) div_cnt_q <= div_cnt_q + tmrcq_pkg::DCW'(1);
		end
	end

	// Result word and walk position; no reset needed.
	always_ff @(posedge clk) begin
		hit <= fin_hit;
		if (state_q == tmrcq_pkg::ST_EVAL) begin
			left_q  <= lft[CW-1:0];
			right_q <= rgt_cl[CW-1:0];
			top_q   <= top[RW-1:0];
			bot_q   <= bot_cl[RW-1:0];
			c_q     <= lft[CW-1:0];
			r_q     <= top[RW-1:0];
		end else if (issue) begin
			// Walk rows of one column, then advance to the next column.
			if (r_q == bot_q) begin
				r_q <= top_q;
				c_q <= c_q + CW'(1);
			end else begin
				r_q <= r_q + RW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	// A result word is never held: done always drops right after it rises.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

	// A tile write causes no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == tmrcq_pkg::FUNC_WRITE)) |=> !done)
		else $error("result after a tile write");

	// Map reads are only in flight while walking or draining.
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == tmrcq_pkg::ST_WALK || state_q == tmrcq_pkg::ST_DRAIN))
		else $error("map read outside the walk");

	// The walk stays inside the clamped range.
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmrcq_pkg::ST_WALK) |->
			(c_q >= left_q && c_q <= right_q && r_q >= top_q && r_q <= bot_q))
		else $error("walk left the tile range");
`endif

endmodule

@@ rtl/tmrcq_div.sv @@
// Restoring unsigned divider, one quotient bit per step.
module tmrcq_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [tmrcq_pkg::QW-1:0]    dvd,
	input  logic [tmrcq_pkg::TSW-1:0]   dvs,
	output logic [tmrcq_pkg::QW-1:0]    quo
);

	logic [tmrcq_pkg::TSW-1:0] rem_q;
	logic [tmrcq_pkg::QW-1:0]  quo_q;
	logic [tmrcq_pkg::TSW:0]   shl;
	logic [tmrcq_pkg::TSW:0]   diff;
	logic                      ge;
	logic [tmrcq_pkg::TSW-1:0] rem_nxt;

	// Shift in the next dividend bit and try one subtract.
	always_comb begin
		shl     = {rem_q, quo_q[tmrcq_pkg::QW-1]};
		ge      = (shl >= {1'b0, dvs});
		diff    = shl - {1'b0, dvs};
		rem_nxt = ge ? diff[tmrcq_pkg::TSW-1:0] : shl[tmrcq_pkg::TSW-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dvd;
		end else if (step) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[tmrcq_pkg::QW-2:0], ge};
		end
	end

	assign quo = quo_q;

endmodule

@@ bench/tilemap_rect_collision_query_test.sv @@
// Self-checking testbench for the tilemap rectangle collision query block.
`timescale 1ns / 1ps

module tilemap_rect_collision_query_test;

	localparam int ROWS = tmrcq_pkg::DEF_MAX_ROWS;
	localparam int COLS = tmrcq_pkg::DEF_MAX_COLS;
	// Corner region written up front; queries only cover written tiles.
	localparam int FILL_ROWS = 8;
	localparam int FILL_COLS = 16;
	// Generous ceiling: every query could walk the whole store.
	localparam longint TIMEOUT_NS = 200_000_000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                func = tmrcq_pkg::FUNC_WRITE;
	logic [5:0]          tile_row = '0;
	logic [6:0]          tile_col = '0;
	logic signed [15:0]  tile_value = '0;
	logic signed [15:0]  query_x = '0;
	logic signed [15:0]  query_y = '0;
	logic [14:0]         query_w = '0;
	logic [14:0]         query_h = '0;
	logic                done;
	logic                hit;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = tmrcq_pkg::REG_MAP_ENABLED;
	logic [tmrcq_pkg::TSW-1:0] cfg_wdata = '0;

	// Shadow copy of the block state: the solid map and the four registers.
	bit                  solid_shadow [0:ROWS-1][0:COLS-1];
	// Tiles written since reset; a query must never read any other.
	bit                  written [0:ROWS-1][0:COLS-1];
	logic                sh_map_enabled = tmrcq_pkg::MAP_ENABLED_RST;
	logic [7:0]          sh_tile_size = tmrcq_pkg::TILE_SIZE_RST;
	logic [6:0]          sh_row_count = tmrcq_pkg::ROW_COUNT_RST;
	logic [7:0]          sh_col_count = tmrcq_pkg::COL_COUNT_RST;

	// Hit answers predicted for accepted queries, oldest first.
	logic                hit_expect_q [$];
	int                  error_count = 0;
	int                  burst_left = 0;

	tilemap_rect_collision_query i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.tile_row   (tile_row),
		.tile_col   (tile_col),
		.tile_value (tile_value),
		.query_x    (query_x),
		.query_y    (query_y),
		.query_w    (query_w),
		.query_h    (query_h),
		.done       (done),
		.hit        (hit),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Effective counts: saturate at the store size.
	function automatic int eff_rows();
		eff_rows = (sh_row_count > ROWS) ? ROWS : int'(sh_row_count);
	endfunction

	function automatic int eff_cols();
		eff_cols = (sh_col_count > COLS) ? COLS : int'(sh_col_count);
	endfunction

	function automatic int eff_tile_size();
		eff_tile_size = (sh_tile_size == 0) ? 1 : int'(sh_tile_size);
	endfunction

	// Divide the edges (truncating toward zero) and clamp to the map.
	function automatic void tile_range(input int x, input int y, input int w, input int h,
			output int left, output int right, output int top, output int bottom);
		int ts;
		ts = eff_tile_size();
		left = x / ts;
		right = (x + w) / ts;
		top = y / ts;
		bottom = (y + h) / ts;
		if (left < 0)
			left = 0;
		if (top < 0)
			top = 0;
		if (right > eff_cols() - 1)
			right = eff_cols() - 1;
		if (bottom > eff_rows() - 1)
			bottom = eff_rows() - 1;
	endfunction

	// Walk the covered tiles when the map is enabled; any solid tile is a hit.
	function automatic logic predict_hit(input int x, input int y, input int w, input int h);
		int left, right, top, bottom;
		logic found;
		found = 1'b0;
		tile_range(x, y, w, h, left, right, top, bottom);
		if (sh_map_enabled) begin
			for (int c = left; c <= right; c++) begin
				for (int r = top; r <= bottom; r++) begin
					if (solid_shadow[r][c])
						found = 1'b1;
				end
			end
		end
		predict_hit = found;
	endfunction

	// True when the query reads only tiles that were written.
	function automatic bit query_safe(input int x, input int y, input int w, input int h);
		int left, right, top, bottom;
		bit ok;
		ok = 1'b1;
		tile_range(x, y, w, h, left, right, top, bottom);
		if (sh_map_enabled) begin
			for (int c = left; c <= right; c++) begin
				for (int r = top; r <= bottom; r++) begin
					if (!written[r][c])
						ok = 1'b0;
				end
			end
		end
		query_safe = ok;
	endfunction

	function automatic int sat16(input int v);
		sat16 = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	// Mostly clear tiles: about one in ten is solid.
	function automatic logic signed [15:0] random_tile_value();
		if ($urandom_range(0, 9) == 0)
			random_tile_value = 16'($urandom_range(1, 32767));
		else
			random_tile_value = 16'(0 - int'($urandom_range(0, 32768)));
	endfunction

	// Present one word and hold it until the block takes it. Start stays
	// high on return; the caller drives it again in this same time step.
	task automatic send_word(input logic f, input logic [5:0] row, input logic [6:0] col,
			input logic signed [15:0] val, input logic signed [15:0] qx,
			input logic signed [15:0] qy, input logic [14:0] qw, input logic [14:0] qh);
		start      <= 1'b1;
		func       <= f;
		tile_row   <= row;
		tile_col   <= col;
		tile_value <= val;
		query_x    <= qx;
		query_y    <= qy;
		query_w    <= qw;
		query_h    <= qh;
		// busy read here is its value before this edge
		do @(posedge clk); while (busy);
		if (f == tmrcq_pkg::FUNC_WRITE) begin
			solid_shadow[row][col] = (val > 0);
			written[row][col] = 1'b1;
		end else begin
			hit_expect_q.push_back(predict_hit(qx, qy, qw, qh));
		end
	endtask

	// Drop start for an idle gap of length n; zero keeps the next word back to back.
	task automatic idle_gap(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Random gap: mostly short, a few long, with stretches of no idling.
	task automatic sender_gap();
		int r, n;
		r = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			n = 0;
		end else begin
			if ($urandom_range(0, 19) == 0)
				burst_left = $urandom_range(10, 40);
			if (r < 50)
				n = 0;
			else if (r < 85)
				n = $urandom_range(1, 3);
			else if (r < 97)
				n = $urandom_range(4, 12);
			else
				n = $urandom_range(20, 60);
		end
		idle_gap(n);
	endtask

	task automatic write_tile(input int row, input int col, input logic signed [15:0] val);
		send_word(tmrcq_pkg::FUNC_WRITE, 6'(row), 7'(col), val,
			16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
		sender_gap();
	endtask

	task automatic query_rect(input int x, input int y, input int w, input int h);
		send_word(tmrcq_pkg::FUNC_QUERY, 6'($urandom), 7'(int'($urandom)), 16'($urandom),
			16'(x), 16'(y), 15'(w), 15'(h));
		sender_gap();
	endtask

	// Hold off the sender until every expected answer has come and the
	// block is back to idle.
	task automatic settle();
		start <= 1'b0;
		while (hit_expect_q.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		repeat (3) @(posedge clk);
	endtask

	// Write all four registers while idle, one per cycle.
	task automatic set_config(input logic [7:0] en, input logic [7:0] ts,
			input logic [7:0] rows, input logic [7:0] cols);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= tmrcq_pkg::REG_MAP_ENABLED;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_index <= tmrcq_pkg::REG_TILE_SIZE;
		cfg_wdata <= ts;
		@(posedge clk);
		cfg_index <= tmrcq_pkg::REG_ROW_COUNT;
		cfg_wdata <= rows;
		@(posedge clk);
		cfg_index <= tmrcq_pkg::REG_COL_COUNT;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sh_map_enabled = en[0];
		sh_tile_size   = ts;
		sh_row_count   = rows[6:0];
		sh_col_count   = cols;
	endtask

	// Map disabled at reset: the answer is no hit without any map read.
	task automatic test_reset_defaults();
		query_rect(0, 0, 100, 100);
	endtask

	// Write every tile of the corner region once.
	task automatic test_fill_map();
		for (int r = 0; r < FILL_ROWS; r++) begin
			for (int c = 0; c < FILL_COLS; c++) begin
				send_word(tmrcq_pkg::FUNC_WRITE, 6'(r), 7'(c), random_tile_value(),
					16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
				idle_gap(($urandom_range(0, 15) == 0) ? 1 : 0);
			end
		end
	endtask

	// Writes land even while the map is disabled; queries then miss.
	task automatic test_map_disabled();
		write_tile(5, 5, 16'sd1);
		query_rect(5 * 32, 5 * 32, 0, 0);
		set_config(8'd1, tmrcq_pkg::TILE_SIZE_RST, 8'(tmrcq_pkg::ROW_COUNT_RST),
			tmrcq_pkg::COL_COUNT_RST);
		query_rect(5 * 32, 5 * 32, 0, 0);
		// rows past the default count of 20 are clamped away
		write_tile(30, 6, 16'sd7);
		query_rect(6 * 32, 25 * 32, 0, 200);
	endtask

	// Extremes of the tile value at the store corners, one pixel per tile.
	task automatic test_tile_value_extremes();
		set_config(8'd1, 8'd1, 8'(ROWS), 8'(COLS));
		write_tile(0, 0, -16'sd32768);
		query_rect(0, 0, 0, 0);
		write_tile(0, 0, 16'sd32767);
		query_rect(0, 0, 0, 0);
		write_tile(ROWS - 1, COLS - 1, 16'sd1);
		query_rect(COLS - 1, ROWS - 1, 0, 0);
		write_tile(ROWS - 1, COLS - 1, 16'sd0);
		query_rect(COLS - 1, ROWS - 1, 0, 0);
	endtask

	task automatic test_query_extremes();
		set_config(8'd1, 8'd32, 8'(FILL_ROWS), 8'(FILL_COLS));
		// wholly above-left, wholly below-right: empty ranges
		query_rect(-32768, -32768, 0, 0);
		query_rect(32767, 32767, 32767, 32767);
		// far edge truncates toward zero onto tile zero
		query_rect(-32768, -32768, 32767, 32767);
		query_rect(-31, -31, 0, 0);
		// straddle a tile boundary
		query_rect(31, 31, 1, 1);
		// cover the whole map
		query_rect(-100, -100, 32767, 32767);
	endtask

	// Zero divisor, zero counts and counts beyond the store.
	task automatic test_special_config();
		set_config(8'd1, 8'd0, 8'(ROWS), 8'(COLS));
		query_rect(5, 3, 0, 0);
		set_config(8'd1, 8'd8, 8'd0, 8'(COLS));
		query_rect(0, 0, 100, 100);
		set_config(8'd1, 8'd8, 8'(ROWS), 8'd0);
		query_rect(0, 0, 100, 100);
		// saturated counts clamp the far corner onto the last tile
		set_config(8'd1, 8'd255, 8'd127, 8'd255);
		write_tile(ROWS - 1, COLS - 1, 16'sd5);
		query_rect((COLS - 1) * 255, (ROWS - 1) * 255, 32767, 32767);
		// longest walk over the written region
		set_config(8'd1, 8'd1, 8'(FILL_ROWS), 8'(FILL_COLS));
		query_rect(0, 0, 32767, 32767);
	endtask

	// Mostly rectangles near the written region with sizes of a few tiles;
	// the rest anywhere, a few of them up to full size. Retry until only written tiles
	// are covered, else fall back to the origin tile.
	task automatic random_query();
		int ts, rows, cols, x, y, w, h, sel, tries;
		ts = eff_tile_size();
		rows = (eff_rows() == 0) ? 1 : eff_rows();
		cols = (eff_cols() == 0) ? 1 : eff_cols();
		if (rows > FILL_ROWS)
			rows = FILL_ROWS;
		if (cols > FILL_COLS)
			cols = FILL_COLS;
		tries = 0;
		do begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				x = int'($urandom_range(0, (cols + 4) * ts)) - 2 * ts;
				y = int'($urandom_range(0, (rows + 4) * ts)) - 2 * ts;
			end else begin
				x = int'($urandom_range(0, 65535)) - 32768;
				y = int'($urandom_range(0, 65535)) - 32768;
			end
			w = $urandom_range(0, 3 * ts);
			h = $urandom_range(0, 3 * ts);
			if (sel >= 95) begin
				w = $urandom_range(0, 32767);
				h = $urandom_range(0, 32767);
			end
			x = sat16(x);
			y = sat16(y);
			if (w > 32767)
				w = 32767;
			if (h > 32767)
				h = 32767;
			tries++;
		end while (!query_safe(x, y, w, h) && tries < 32);
		if (!query_safe(x, y, w, h)) begin
			x = 0;
			y = 0;
			w = 0;
			h = 0;
		end
		query_rect(x, y, w, h);
	endtask

	task automatic test_random();
		logic [7:0] en, ts, rows, cols;
		for (int phase = 0; phase < 8; phase++) begin
			en = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'd1;
			case ($urandom_range(0, 3))
				0: ts = 8'd1;
				1: ts = 8'd255;
				default: ts = 8'($urandom_range(1, 64));
			endcase
			if ($urandom_range(0, 6) != 0)
				rows = 8'($urandom_range(1, FILL_ROWS));
			else
				rows = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(ROWS + 1, 127));
			if ($urandom_range(0, 6) != 0)
				cols = 8'($urandom_range(1, FILL_COLS));
			else
				cols = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(COLS + 1, 255));
			// pin the extremes in the first phases
			case (phase)
				0: begin
					en = 8'd1; ts = 8'd1; rows = 8'(ROWS); cols = 8'(COLS);
				end
				1: begin
					en = 8'd1; ts = 8'd255; rows = 8'd1; cols = 8'd1;
				end
				2: begin
					en = 8'd1; ts = 8'd32; rows = 8'(ROWS); cols = 8'(COLS);
				end
				default: ;
			endcase
			set_config(en, ts, rows, cols);
			for (int i = 0; i < 55; i++) begin
				if (i == 30 || $urandom_range(0, 49) == 0)
					settle();
				if ($urandom_range(0, 99) < 35) begin
					if ($urandom_range(0, 4) != 0)
						write_tile($urandom_range(0, FILL_ROWS - 1),
							$urandom_range(0, FILL_COLS - 1), random_tile_value());
					else
						write_tile($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
							random_tile_value());
				end else begin
					random_query();
				end
			end
		end
	endtask

	// Compare each answer word against the oldest prediction.
	always @(posedge clk) begin
		logic exp_hit;
		if (arst_n && done) begin
			if (hit_expect_q.size() == 0) begin
				$error("unexpected result word: hit actual %0b", hit);
				error_count++;
			end else begin
				exp_hit = hit_expect_q.pop_front();
				if (hit !== exp_hit) begin
					$error("hit mismatch: expected %0b, actual %0b", exp_hit, hit);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_fill_map();
		test_map_disabled();
		test_tile_value_extremes();
		test_query_extremes();
		test_special_config();
		test_random();
		// wait out the last answers, then a little past the query latency
		settle();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("PASS tilemap_rect_collision_query");
		else
			$display("FAIL tilemap_rect_collision_query");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL tilemap_rect_collision_query");
		$finish;
	end

endmodule
